// ===== rtl/otsu_pkg.sv =====
package otsu_pkg;

    localparam int LEVEL_W = 8;
    localparam int THR_W   = 9;

    localparam logic OP_ACCUM    = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic KIND_REPORT   = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } otsu_in_t;

    typedef struct packed {
        logic             kind;
        logic             white;
        logic [THR_W-1:0] threshold;
    } otsu_out_t;

endpackage

// ===== rtl/otsu_mul.sv =====
// Shift-add multiplier: one partial-product bit per cycle.
module otsu_mul #(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] p
);
    localparam int CW = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW+BW-1:0] a_reg, a_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            acc_next = '0;
            a_next   = {{BW{1'b0}}, a};
            b_next   = b;
            cnt_next = CW'(BW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

`ifndef ASSERT_OFF
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg))
        else $error("done without run");
    a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> !run_reg)
        else $error("go while busy");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("run after done");
`endif

endmodule

// ===== rtl/otsu_threshold_binarizer.sv =====
// Otsu binarizer for 8-bit grey levels. After reset the block clears its histogram memory
// in a sweep over all LEVELS bins with busy high, and produces no result for that sweep.
// Accumulate items (op=0) count the level into a LEVELS-bin histogram held in a memory with
// one read and one write port; each one keeps busy high for a read, then a saturating write
// back. An accumulate item with last set runs the threshold scan: a sweep that sums the
// bins, then for each bin from the first to the last nonzero one six products on one shared
// shift-add multiplier; the last nonzero bin has a zero denominator and needs only four
// products. A clearing sweep over all bins and the output state end the scan. Classify
// items (op=1) keep busy high for one cycle and put their result out through the output
// state and the strobe register. busy is high from acceptance until the strobe; each
// result is on result for one cycle with strobe high, and the receiver cannot stall it.
module otsu_threshold_binarizer #(
    parameter int COUNT_BITS = 24,
    parameter int LEVELS     = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  otsu_pkg::otsu_in_t  item,
    output logic                busy,
    output logic                strobe,
    output otsu_pkg::otsu_out_t result
);
    import otsu_pkg::*;

    localparam int IW  = $clog2(LEVELS);
    localparam int BW  = IW + 1;               // bin index 1..LEVELS
    localparam int NW  = COUNT_BITS + IW;      // pixel count sum
    localparam int SW  = NW + BW;              // weighted sum
    localparam int PW  = SW + NW;              // one cross product
    localparam int QW  = 2 * PW;               // squared difference
    localparam int DW  = 2 * NW;               // denominator
    localparam int MW  = QW + DW;              // compare product
    localparam int MAW = QW;                   // multiplier operand widths
    localparam int MBW = (PW > DW) ? PW : DW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ACC_R = 4'd1;
    localparam logic [3:0] S_ACC_W = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_M1    = 4'd5;
    localparam logic [3:0] S_M2    = 4'd6;
    localparam logic [3:0] S_M3    = 4'd7;
    localparam logic [3:0] S_M4    = 4'd8;
    localparam logic [3:0] S_M5    = 4'd9;
    localparam logic [3:0] S_CMP   = 4'd10;
    localparam logic [3:0] S_CLR   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_M4D   = 4'd13;

    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // histogram memory
    logic [COUNT_BITS-1:0] hist_mem [LEVELS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  we;
    logic [IW-1:0]         waddr, raddr;
    logic [COUNT_BITS-1:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            hist_mem[waddr] <= wdata;
        rd_data_reg <= hist_mem[raddr];
    end

    logic [3:0]      state_reg, state_next;
    logic [BW-1:0]   idx_reg, idx_next;       // bin index being processed
    logic [BW-1:0]   first_reg, first_next, lastnz_reg, lastnz_next;
    logic [NW-1:0]   n_reg, n_next, w_reg, w_next;
    logic [SW-1:0]   t_reg, t_next, u_reg, u_next;
    logic [PW-1:0]   pa_reg, pa_next;
    logic [QW-1:0]   num_reg, num_next, bnum_reg, bnum_next;
    logic [DW-1:0]   den_reg, den_next, bden_reg, bden_next;
    logic [MW-1:0]   l_reg, l_next;
    logic            have_reg, have_next;
    logic            init_reg, init_next;
    logic            mgo_reg, mgo_next;
    logic [MAW-1:0]  ma_reg, ma_next;
    logic [MBW-1:0]  mb_reg, mb_next;
    logic [THR_W-1:0] thr_reg, thr_next, best_reg, best_next;
    logic [IW-1:0]   lvl_reg, lvl_next;
    otsu_in_t        in_reg, in_next;
    otsu_out_t       res_reg, res_next;
    logic            stb_reg, stb_next;

    logic             mdone;
    logic [MAW+MBW-1:0] mp;

    otsu_mul #(.AW(MAW), .BW(MBW)) u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mgo_reg),
        .a    (ma_reg),
        .b    (mb_reg),
        .done (mdone),
        .p    (mp)
    );

    logic [NW-1:0] v_c;
    logic [PW-1:0] pb_c;
    logic [PW-1:0] diff_c;
    logic [BW-1:0] rd_idx_c;

    always_comb
    begin
        v_c      = n_reg - w_reg;
        pb_c     = mp[PW-1:0];
        diff_c   = (pa_reg >= pb_c) ? (pa_reg - pb_c) : (pb_c - pa_reg);
        rd_idx_c = idx_reg - 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        first_next  = first_reg;
        lastnz_next = lastnz_reg;
        n_next      = n_reg;
        w_next      = w_reg;
        t_next      = t_reg;
        u_next      = u_reg;
        pa_next     = pa_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        bnum_next   = bnum_reg;
        bden_next   = bden_reg;
        l_next      = l_reg;
        have_next   = have_reg;
        init_next   = init_reg;
        mgo_next    = 1'b0;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        thr_next    = thr_reg;
        best_next   = best_reg;
        lvl_next    = lvl_reg;
        in_next     = in_reg;
        res_next    = res_reg;
        stb_next    = 1'b0;
        we          = 1'b0;
        waddr       = lvl_reg;
        wdata       = '0;
        raddr       = lvl_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    in_next = item;
                    // clamp levels past the top bin
                    if (32'(item.level) >= LEVELS)
                        lvl_next = IW'(LEVELS - 1);
                    else
                        lvl_next = item.level[IW-1:0];
                    if (item.op == OP_CLASSIFY)
                    begin
                        res_next.kind      = KIND_CLASSIFY;
                        res_next.white     = ({1'b0, item.level} >= thr_reg);
                        res_next.threshold = thr_reg;
                        state_next         = S_OUT;
                    end
                    else
                        state_next = S_ACC_R;
                end
            end
            S_ACC_R:
            begin
                raddr      = lvl_reg;
                state_next = S_ACC_W;
            end
            S_ACC_W:
            begin
                // saturating increment
                we    = 1'b1;
                waddr = lvl_reg;
                wdata = (rd_data_reg == CMAX) ? rd_data_reg : rd_data_reg + 1'b1;
                if (in_reg.last)
                begin
                    idx_next    = '0;
                    n_next      = '0;
                    t_next      = '0;
                    first_next  = '0;
                    lastnz_next = '0;
                    state_next  = S_SUM;
                end
                else
                    state_next = S_IDLE;
            end
            S_SUM:
            begin
                // idx_reg = bin whose data is now in rd_data_reg; 0 means none yet
                raddr = idx_reg[IW-1:0];
                if (idx_reg != '0)
                begin
                    n_next = n_reg + NW'(rd_data_reg);
                    t_next = t_reg + SW'(rd_data_reg) * SW'(idx_reg);
                    if (rd_data_reg != '0)
                    begin
                        if (first_reg == '0)
                            first_next = idx_reg;
                        lastnz_next = idx_reg;
                    end
                end
                if (32'(idx_reg) == LEVELS)
                begin
                    if (first_next == '0 || first_next == lastnz_next)
                    begin
                        best_next  = '0;
                        idx_next   = '0;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        idx_next   = first_next;
                        w_next     = '0;
                        u_next     = '0;
                        have_next  = 1'b0;
                        bnum_next  = '0;
                        bden_next  = DW'(1);
                        state_next = S_RD;
                    end
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_RD:
            begin
                // issue the read of this bin, then update running sums
                raddr      = rd_idx_c[IW-1:0];
                state_next = S_M1;
                mgo_next   = 1'b0;
            end
            S_M1:
            begin
                // fold the bin in and start uup*w
                w_next   = w_reg + NW'(rd_data_reg);
                u_next   = u_reg + SW'(rd_data_reg) * SW'(idx_reg);
                ma_next  = MAW'(t_reg - (u_reg + SW'(rd_data_reg) * SW'(idx_reg)));
                mb_next  = MBW'(w_reg + NW'(rd_data_reg));
                mgo_next = 1'b1;
                state_next = S_M2;
            end
            S_M2:
            begin
                if (mdone)
                begin
                    pa_next  = mp[PW-1:0];
                    ma_next  = MAW'(u_reg);
                    mb_next  = MBW'(v_c);
                    mgo_next = 1'b1;
                    state_next = S_M3;
                end
            end
            S_M3:
            begin
                if (mdone)
                begin
                    if (w_reg == '0 || v_c == '0)
                    begin
                        num_next   = '0;
                        den_next   = DW'(1);
                        ma_next    = '0;
                        mb_next    = MBW'(bden_reg);
                        mgo_next   = 1'b1;
                        state_next = S_M5;
                    end
                    else
                    begin
                        ma_next    = MAW'(diff_c);
                        mb_next    = MBW'(diff_c);
                        mgo_next   = 1'b1;
                        state_next = S_M4;
                    end
                end
            end
            S_M4:
            begin
                // squared diff, then start w*v
                if (mdone)
                begin
                    num_next   = mp[QW-1:0];
                    ma_next    = MAW'(v_c);
                    mb_next    = MBW'(w_reg);
                    mgo_next   = 1'b1;
                    state_next = S_M4D;
                end
            end
            S_M4D:
            begin
                if (mdone)
                begin
                    den_next   = mp[DW-1:0];
                    ma_next    = num_reg;
                    mb_next    = MBW'(bden_reg);
                    mgo_next   = 1'b1;
                    state_next = S_M5;
                end
            end
            S_M5:
            begin
                // l = num*bestden, then r = bestnum*den
                if (mdone)
                begin
                    l_next     = mp[MW-1:0];
                    ma_next    = bnum_reg;
                    mb_next    = MBW'(den_reg);
                    mgo_next   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (mdone)
                begin
                    if (!have_reg || l_reg >= mp[MW-1:0])
                    begin
                        have_next = 1'b1;
                        bnum_next = num_reg;
                        bden_next = den_reg;
                        best_next = THR_W'(idx_reg);
                    end
                    if (idx_reg == lastnz_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_CLR:
            begin
                we    = 1'b1;
                waddr = idx_reg[IW-1:0];
                wdata = '0;
                if (32'(idx_reg) == LEVELS - 1)
                begin
                    init_next = 1'b0;
                    // the sweep after reset reports nothing
                    if (init_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        thr_next           = best_reg;
                        res_next.kind      = KIND_REPORT;
                        res_next.white     = 1'b0;
                        res_next.threshold = best_reg;
                        state_next         = S_OUT;
                    end
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_OUT:
            begin
                stb_next   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;     // clear the histogram after reset
            idx_reg   <= '0;
            thr_reg   <= '0;
            best_reg  <= '0;
            stb_reg   <= 1'b0;
            mgo_reg   <= 1'b0;
            have_reg  <= 1'b0;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            thr_reg   <= thr_next;
            best_reg  <= best_next;
            stb_reg   <= stb_next;
            mgo_reg   <= mgo_next;
            have_reg  <= have_next;
            init_reg  <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        lastnz_reg <= lastnz_next;
        n_reg      <= n_next;
        w_reg      <= w_next;
        t_reg      <= t_next;
        u_reg      <= u_next;
        pa_reg     <= pa_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        bnum_reg   <= bnum_next;
        bden_reg   <= bden_next;
        l_reg      <= l_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        lvl_reg    <= lvl_next;
        in_reg     <= in_next;
        res_reg    <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = stb_reg;
    assign result = res_reg;

`ifndef ASSERT_OFF
    a_strobe_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        stb_reg |-> $past(state_reg) == S_OUT)
        else $error("strobe without output state");
    a_idle_after_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        stb_reg |-> state_reg == S_IDLE)
        else $error("not idle after result");
    a_report_white_low: assert property (@(posedge clk) disable iff (!rst_n)
        (stb_reg && res_reg.kind == KIND_REPORT) |-> !res_reg.white)
        else $error("report carries white");
    a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(thr_reg) <= LEVELS)
        else $error("threshold out of range");
`endif

endmodule
